// ===== sv/cpvcl_pkg.sv =====
package cpvcl_pkg;

    localparam int PWM_PERIOD     = 4096;
    localparam int HALF_PERIOD    = PWM_PERIOD / 2;
    localparam int GAIN_FRAC_BITS = 13;
    localparam int DUTY_FRAC_BITS = 17;

    localparam int GAIN_W  = 16;
    localparam int LIMIT_W = 18;
    localparam int SAMP_W  = 24;
    localparam int WORD_W  = 32;
    localparam int PWM_W   = 16;
    localparam int PROD_W  = GAIN_W + 1 + WORD_W;

    localparam int IN_TDATA_W  = 4 * SAMP_W;
    localparam int OUT_TDATA_W = 64;
    localparam int CFG_IDX_W   = 3;

    localparam int UCODE_LEN = 17;
    localparam int PC_W      = $clog2(UCODE_LEN);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_KP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_KI      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_KC      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CURR_KP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CURR_KI      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CURR_KC      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CURR_OUT_MAX = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CURR_OUT_MIN = 3'd7;

    localparam logic [GAIN_W-1:0]  RST_VOLT_KP      = 16'd7372;
    localparam logic [GAIN_W-1:0]  RST_VOLT_KI      = 16'd4096;
    localparam logic [GAIN_W-1:0]  RST_VOLT_KC      = 16'd4096;
    localparam logic [GAIN_W-1:0]  RST_CURR_KP      = 16'd2048;
    localparam logic [GAIN_W-1:0]  RST_CURR_KI      = 16'd90;
    localparam logic [GAIN_W-1:0]  RST_CURR_KC      = 16'd819;
    localparam logic [LIMIT_W-1:0] RST_CURR_OUT_MAX = 18'd124518;
    localparam logic [LIMIT_W-1:0] RST_CURR_OUT_MIN = 18'd131;

    // Datapath operations.
    localparam logic [2:0] OP_NOP    = 3'd0;
    localparam logic [2:0] OP_LOAD   = 3'd1;
    localparam logic [2:0] OP_ERR    = 3'd2;
    localparam logic [2:0] OP_UP     = 3'd3;
    localparam logic [2:0] OP_INTADD = 3'd4;
    localparam logic [2:0] OP_PRE    = 3'd5;
    localparam logic [2:0] OP_CLAMP  = 3'd6;
    localparam logic [2:0] OP_RESULT = 3'd7;

    // Multiplier operand selects.
    localparam logic [1:0] MA_KP    = 2'd0;
    localparam logic [1:0] MA_KI    = 2'd1;
    localparam logic [1:0] MA_KC    = 2'd2;
    localparam logic [1:0] MA_HALFP = 2'd3;

    localparam logic [1:0] MB_ERR  = 2'd0;
    localparam logic [1:0] MB_UP   = 2'd1;
    localparam logic [1:0] MB_SAT  = 2'd2;
    localparam logic [1:0] MB_DUTY = 2'd3;

    // Step conditions; a step whose condition is not met repeats.
    localparam logic [1:0] COND_NONE = 2'd0;
    localparam logic [1:0] COND_IN   = 2'd1;
    localparam logic [1:0] COND_OUT  = 2'd2;

    localparam logic LOOP_VOLT = 1'b0;
    localparam logic LOOP_CURR = 1'b1;

    typedef struct packed {
        logic [2:0] op;
        logic       loop_sel;
        logic       mul_en;
        logic [1:0] ma_sel;
        logic [1:0] mb_sel;
    } dp_ctrl_t;

    typedef struct packed {
        logic [1:0] cond;
        logic       last;
        dp_ctrl_t   ctrl;
    } ucode_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  volt_kp;
        logic [GAIN_W-1:0]  volt_ki;
        logic [GAIN_W-1:0]  volt_kc;
        logic [GAIN_W-1:0]  curr_kp;
        logic [GAIN_W-1:0]  curr_ki;
        logic [GAIN_W-1:0]  curr_kc;
        logic [LIMIT_W-1:0] curr_out_max;
        logic [LIMIT_W-1:0] curr_out_min;
    } cfg_t;

    function automatic ucode_t mk(input logic [1:0] cond, input logic last,
                                  input logic [2:0] op, input logic loop_sel,
                                  input logic mul_en, input logic [1:0] ma,
                                  input logic [1:0] mb);
        ucode_t w;
        w.cond          = cond;
        w.last          = last;
        w.ctrl.op       = op;
        w.ctrl.loop_sel = loop_sel;
        w.ctrl.mul_en   = mul_en;
        w.ctrl.ma_sel   = ma;
        w.ctrl.mb_sel   = mb;
        return w;
    endfunction

    // The control program: outer voltage loop, inner current loop, PWM scaling.
    function automatic ucode_t ucode_word(input logic [PC_W-1:0] pc);
        ucode_t w;
        unique case (pc)
            5'd0:  w = mk(COND_IN,   1'b0, OP_LOAD,   LOOP_VOLT, 1'b0, MA_KP,    MB_ERR);
            5'd1:  w = mk(COND_NONE, 1'b0, OP_ERR,    LOOP_VOLT, 1'b0, MA_KP,    MB_ERR);
            5'd2:  w = mk(COND_NONE, 1'b0, OP_NOP,    LOOP_VOLT, 1'b1, MA_KP,    MB_ERR);
            5'd3:  w = mk(COND_NONE, 1'b0, OP_UP,     LOOP_VOLT, 1'b1, MA_KC,    MB_SAT);
            5'd4:  w = mk(COND_NONE, 1'b0, OP_INTADD, LOOP_VOLT, 1'b1, MA_KI,    MB_UP);
            5'd5:  w = mk(COND_NONE, 1'b0, OP_INTADD, LOOP_VOLT, 1'b0, MA_KP,    MB_ERR);
            5'd6:  w = mk(COND_NONE, 1'b0, OP_PRE,    LOOP_VOLT, 1'b0, MA_KP,    MB_ERR);
            5'd7:  w = mk(COND_NONE, 1'b0, OP_CLAMP,  LOOP_VOLT, 1'b0, MA_KP,    MB_ERR);
            5'd8:  w = mk(COND_NONE, 1'b0, OP_ERR,    LOOP_CURR, 1'b0, MA_KP,    MB_ERR);
            5'd9:  w = mk(COND_NONE, 1'b0, OP_NOP,    LOOP_CURR, 1'b1, MA_KP,    MB_ERR);
            5'd10: w = mk(COND_NONE, 1'b0, OP_UP,     LOOP_CURR, 1'b1, MA_KC,    MB_SAT);
            5'd11: w = mk(COND_NONE, 1'b0, OP_INTADD, LOOP_CURR, 1'b1, MA_KI,    MB_UP);
            5'd12: w = mk(COND_NONE, 1'b0, OP_INTADD, LOOP_CURR, 1'b0, MA_KP,    MB_ERR);
            5'd13: w = mk(COND_NONE, 1'b0, OP_PRE,    LOOP_CURR, 1'b0, MA_KP,    MB_ERR);
            5'd14: w = mk(COND_NONE, 1'b0, OP_CLAMP,  LOOP_CURR, 1'b0, MA_KP,    MB_ERR);
            5'd15: w = mk(COND_NONE, 1'b0, OP_NOP,    LOOP_CURR, 1'b1, MA_HALFP, MB_DUTY);
            5'd16: w = mk(COND_OUT,  1'b1, OP_RESULT, LOOP_CURR, 1'b0, MA_KP,    MB_ERR);
            default: w = mk(COND_NONE, 1'b1, OP_NOP,  LOOP_VOLT, 1'b0, MA_KP,    MB_ERR);
        endcase
        return w;
    endfunction

endpackage

// ===== sv/cpvcl_seq.sv =====
module cpvcl_seq
    import cpvcl_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output dp_ctrl_t ctrl
);

    logic [PC_W-1:0] pc_reg, pc_next;
    logic            m_tvalid_reg, m_tvalid_next;
    ucode_t          word;
    logic            hold;
    logic            emit;

    always_comb begin
        word = ucode_word(pc_reg);
        hold = ((word.cond == COND_IN) && !s_tvalid) ||
               ((word.cond == COND_OUT) && m_tvalid_reg && !m_tready);
        emit = !hold && (word.ctrl.op == OP_RESULT);

        ctrl = word.ctrl;
        if (hold) begin
            ctrl.op     = OP_NOP;
            ctrl.mul_en = 1'b0;
        end

        if (hold) begin
            pc_next = pc_reg;
        end else if (word.last) begin
            pc_next = '0;
        end else begin
            pc_next = pc_reg + PC_W'(1);
        end

        if (emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            pc_reg       <= pc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (word.cond == COND_IN);
    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== sv/cpvcl_dp.sv =====
module cpvcl_dp
    import cpvcl_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dp_ctrl_t               ctrl,
    input  cfg_t                   cfg,
    input  logic [IN_TDATA_W-1:0]  in_data,
    output logic [OUT_TDATA_W-1:0] out_data
);

    logic [SAMP_W-1:0]  iref_reg, vref_reg, ifbk_reg, vfbk_reg;
    logic [WORD_W-1:0]  err_reg, up_reg, pre_reg;
    logic [WORD_W-1:0]  vint_reg, vsat_reg, cint_reg, csat_reg;
    logic [SAMP_W-1:0]  icmd_reg;
    logic [LIMIT_W-1:0] duty_reg;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [PWM_W-1:0]   pwm_out_reg;
    logic [SAMP_W-1:0]  icmd_out_reg;
    logic [LIMIT_W-1:0] duty_out_reg;

    logic [SAMP_W-1:0]  ref_sel, fbk_sel;
    logic [WORD_W-1:0]  integ_sel, sat_sel, hi_sel, lo_sel;
    logic [GAIN_W-1:0]  mul_a;
    logic [WORD_W-1:0]  mul_b;
    logic [WORD_W-1:0]  gain_res;
    logic [WORD_W-1:0]  clamp_out;

    always_comb begin
        ref_sel   = ctrl.loop_sel ? icmd_reg : vref_reg;
        fbk_sel   = ctrl.loop_sel ? ifbk_reg : vfbk_reg;
        integ_sel = ctrl.loop_sel ? cint_reg : vint_reg;
        sat_sel   = ctrl.loop_sel ? csat_reg : vsat_reg;
        hi_sel    = ctrl.loop_sel ? WORD_W'(cfg.curr_out_max) : WORD_W'(iref_reg);
        lo_sel    = ctrl.loop_sel ? WORD_W'(cfg.curr_out_min) : '0;

        unique case (ctrl.ma_sel)
            MA_KP:    mul_a = ctrl.loop_sel ? cfg.curr_kp : cfg.volt_kp;
            MA_KI:    mul_a = ctrl.loop_sel ? cfg.curr_ki : cfg.volt_ki;
            MA_KC:    mul_a = ctrl.loop_sel ? cfg.curr_kc : cfg.volt_kc;
            MA_HALFP: mul_a = GAIN_W'(HALF_PERIOD);
            default:  mul_a = '0;
        endcase

        unique case (ctrl.mb_sel)
            MB_ERR:  mul_b = err_reg;
            MB_UP:   mul_b = up_reg;
            MB_SAT:  mul_b = sat_sel;
            MB_DUTY: mul_b = WORD_W'(duty_reg);
            default: mul_b = '0;
        endcase

        prod_next = PROD_W'($signed({1'b0, mul_a}) * $signed(mul_b));
        gain_res  = prod_reg[GAIN_FRAC_BITS +: WORD_W];

        priority if (!($signed(pre_reg) < $signed(hi_sel))) begin
            clamp_out = hi_sel;
        end else if (!($signed(lo_sel) < $signed(pre_reg))) begin
            clamp_out = lo_sel;
        end else begin
            clamp_out = pre_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= prod_next;
        end
        unique case (ctrl.op)
            OP_LOAD: begin
                iref_reg <= in_data[0*SAMP_W +: SAMP_W];
                vref_reg <= in_data[1*SAMP_W +: SAMP_W];
                ifbk_reg <= in_data[2*SAMP_W +: SAMP_W];
                vfbk_reg <= in_data[3*SAMP_W +: SAMP_W];
            end
            OP_ERR: err_reg <= WORD_W'(ref_sel) - WORD_W'(fbk_sel);
            OP_UP:  up_reg  <= gain_res;
            OP_PRE: pre_reg <= up_reg + integ_sel;
            OP_CLAMP: begin
                if (ctrl.loop_sel) begin
                    duty_reg <= clamp_out[LIMIT_W-1:0];
                end else begin
                    icmd_reg <= clamp_out[SAMP_W-1:0];
                end
            end
            OP_RESULT: begin
                pwm_out_reg  <= prod_reg[DUTY_FRAC_BITS +: PWM_W];
                icmd_out_reg <= icmd_reg;
                duty_out_reg <= duty_reg;
            end
            default: begin
            end
        endcase
    end

    // Loop state carried from sample to sample.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vint_reg <= '0;
            vsat_reg <= '0;
            cint_reg <= '0;
            csat_reg <= '0;
        end else if (ctrl.op == OP_INTADD) begin
            if (ctrl.loop_sel) begin
                cint_reg <= cint_reg + gain_res;
            end else begin
                vint_reg <= vint_reg + gain_res;
            end
        end else if (ctrl.op == OP_CLAMP) begin
            if (ctrl.loop_sel) begin
                csat_reg <= clamp_out - pre_reg;
            end else begin
                vsat_reg <= clamp_out - pre_reg;
            end
        end
    end

    assign out_data = {(OUT_TDATA_W - PWM_W - SAMP_W - LIMIT_W)'(0),
                       duty_out_reg, icmd_out_reg, pwm_out_reg};

endmodule

// ===== sv/cascaded_pi_voltage_current_loop.sv =====
// Channel   Direction  tdata fields, lowest bit first
// s_        in         current_ref[23:0], voltage_ref[47:24], current_fbk[71:48],
//                      voltage_fbk[95:72]
// m_        out        pwm_compare[15:0], current_command[39:16], duty_q17[57:40]
// cfg_      in         write only, index 0..7 in register order
//
// Each request runs through the 17 steps of the control program, which share one
// 17x32 multiplier; the request is accepted at the first of them.
// A new request is taken only while the program waits at its first step.
// A finished result waits in the output register and only the final step
// stalls if the previous result has not been taken yet.
// Reset is synchronous; it clears the loop integrators, saturation errors, the step counter
// and the output valid flag, and sets the configuration registers to their defaults.
module cascaded_pi_voltage_current_loop
    import cpvcl_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // current_ref, voltage_ref, current_fbk, voltage_fbk
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // pwm_compare, current_command, duty_q17, zeros
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [LIMIT_W-1:0]     cfg_wdata
);

    cfg_t     cfg_reg;
    dp_ctrl_t ctrl;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.volt_kp      <= RST_VOLT_KP;
            cfg_reg.volt_ki      <= RST_VOLT_KI;
            cfg_reg.volt_kc      <= RST_VOLT_KC;
            cfg_reg.curr_kp      <= RST_CURR_KP;
            cfg_reg.curr_ki      <= RST_CURR_KI;
            cfg_reg.curr_kc      <= RST_CURR_KC;
            cfg_reg.curr_out_max <= RST_CURR_OUT_MAX;
            cfg_reg.curr_out_min <= RST_CURR_OUT_MIN;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_VOLT_KP:      cfg_reg.volt_kp      <= cfg_wdata[GAIN_W-1:0];
                REG_VOLT_KI:      cfg_reg.volt_ki      <= cfg_wdata[GAIN_W-1:0];
                REG_VOLT_KC:      cfg_reg.volt_kc      <= cfg_wdata[GAIN_W-1:0];
                REG_CURR_KP:      cfg_reg.curr_kp      <= cfg_wdata[GAIN_W-1:0];
                REG_CURR_KI:      cfg_reg.curr_ki      <= cfg_wdata[GAIN_W-1:0];
                REG_CURR_KC:      cfg_reg.curr_kc      <= cfg_wdata[GAIN_W-1:0];
                REG_CURR_OUT_MAX: cfg_reg.curr_out_max <= cfg_wdata;
                REG_CURR_OUT_MIN: cfg_reg.curr_out_min <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    cpvcl_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctrl     (ctrl)
    );

    cpvcl_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .cfg      (cfg_reg),
        .in_data  (s_tdata),
        .out_data (m_tdata)
    );

endmodule

// ===== sv/cpvcl_check.sv =====
module cpvcl_check
    import cpvcl_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    logic [LIMIT_W+PWM_W-1:0] pwm_prod;
    logic [PWM_W-1:0]         pwm_expect;

    assign pwm_prod   = (LIMIT_W + PWM_W)'(m_tdata[57:40]) * (LIMIT_W + PWM_W)'(HALF_PERIOD);
    assign pwm_expect = pwm_prod[DUTY_FRAC_BITS +: PWM_W];

    a_one_request_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while the previous one is still being computed");

    a_no_result_right_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("result appeared one cycle after a request was accepted");

    a_pwm_matches_duty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:0] == pwm_expect) && (m_tdata[63:58] == 6'd0))
        else $error("compare value does not follow the delivered duty");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed or was dropped");

endmodule

bind cascaded_pi_voltage_current_loop cpvcl_check u_cpvcl_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
